// ===== hdl/lbf_pkg.sv =====
// Shared types, constants and helpers for the learning bridge forwarder.
package lbf_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_COUNT    = 8;

    localparam int ADDR_W  = 48;
    localparam int PORT_W  = 3;
    localparam int ACT_W   = 4;
    localparam int MASK_W  = 8;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = ADDR_W + PORT_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PORTS = CFG_IDX_W'(1);

    localparam logic [ADDR_W-1:0] BCAST_RESET  = {ADDR_W{1'b1}};
    localparam logic [ACT_W-1:0]  ACTIVE_RESET = ACT_W'(8);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FIN
    } t_state;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNICAST = 2'd0,
        KIND_BCAST   = 2'd1,
        KIND_FLOOD   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0] bcast_addr;
        logic [ACT_W-1:0]  active_ports;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic [MASK_W-1:0] egress_mask;
        t_kind             kind;
        logic              learned;
        logic              full;
    } t_result;

    function automatic logic [MASK_W-1:0] active_mask(input logic [ACT_W-1:0] act);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (ACT_W'(i) < act) && (i < PORT_COUNT);
        end
        return m;
    endfunction

    function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] port);
        return MASK_W'(1) << port;
    endfunction

endpackage

// ===== hdl/lbf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lbf_ctrl.sv =====
// Table sequencer: scans learned entries, learns the source, forms the forwarding decision.
module lbf_ctrl
    import lbf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ADDR_W-1:0]   i_source_address,
    input  logic [ADDR_W-1:0]   i_destination_address,
    input  logic [PORT_W-1:0]   i_ingress_port,
    input  t_cfg                i_cfg,
    output t_mem_req            o_mem,
    input  logic [ENTRY_W-1:0]  i_rd_data,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output t_result             o_res
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_vld;
    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_dst;
    logic [PORT_W-1:0]  r_ingress;
    logic               r_src_hit;
    logic               r_dst_hit;
    logic [PORT_W-1:0]  r_dst_port;

    logic               accept;
    logic               done;
    logic               last_rd;
    logic               tbl_full;
    logic               learn;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PORT_W-1:0]  rd_port;
    logic [MASK_W-1:0]  act;

    assign accept   = i_valid && o_ready;
    assign done     = o_res_valid && i_res_ready;
    assign last_rd  = (CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count;
    assign tbl_full = r_count == CNT_W'(TABLE_ENTRIES);
    assign learn    = !r_src_hit && !tbl_full;
    assign rd_addr  = i_rd_data[ENTRY_W-1:PORT_W];
    assign rd_port  = i_rd_data[PORT_W-1:0];
    assign act      = active_mask(i_cfg.active_ports);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (r_count == '0) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (last_rd) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: n_state = S_FIN;
            S_FIN: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = r_state == S_IDLE;
        o_res_valid = r_state == S_FIN;
        o_mem.re    = r_state == S_SCAN;
        o_mem.raddr = r_rd_idx;
        o_mem.we    = done && learn;
        o_mem.waddr = r_count[IDX_W-1:0];
        o_mem.wdata = {r_src, r_ingress};

        o_res.learned = learn;
        o_res.full    = !r_src_hit && tbl_full;
        if (r_dst == i_cfg.bcast_addr) begin
            o_res.kind        = KIND_BCAST;
            o_res.egress_mask = act & ~port_bit(r_ingress);
        end else if (r_dst_hit) begin
            o_res.kind        = KIND_UNICAST;
            o_res.egress_mask = act & port_bit(r_dst_port);
        end else if (learn && r_dst == r_src) begin
            o_res.kind        = KIND_UNICAST;
            o_res.egress_mask = act & port_bit(r_ingress);
        end else begin
            o_res.kind        = KIND_FLOOD;
            o_res.egress_mask = act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_state == S_SCAN;
            if (done && learn) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src      <= i_source_address;
            r_dst      <= i_destination_address;
            r_ingress  <= i_ingress_port;
            r_rd_idx   <= '0;
            r_src_hit  <= 1'b0;
            r_dst_hit  <= 1'b0;
        end else begin
            if (r_state == S_SCAN) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if (r_rd_vld) begin
                if (rd_addr == r_src) begin
                    r_src_hit <= 1'b1;
                end
                if (rd_addr == r_dst && !r_dst_hit) begin
                    r_dst_hit  <= 1'b1;
                    r_dst_port <= rd_port;
                end
            end
        end
    end

endmodule

// ===== hdl/learning_bridge_forwarder.sv =====
// Top level of the learning bridge forwarder: config registers, address table, result register.
//
//  channel   handshake               payload
//  request   i_valid / o_ready       i_source_address, i_destination_address, i_ingress_port
//  result    o_valid / i_ready       o_egress_mask, o_forward_kind, o_source_learned, o_table_full
//  config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  A request scans every learned entry (none when the table is empty) before its result:
//  the table RAM is scanned one entry per cycle through its single read port.
//  Reset empties the table by zeroing the fill count; entries fill from index 0.
//  A finished result is held in the output register; a new request is taken
//  while it waits, and the sequencer stalls at its last step until the slot frees.
module learning_bridge_forwarder
    import lbf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [ADDR_W-1:0]    i_source_address,
    input  logic [ADDR_W-1:0]    i_destination_address,
    input  logic [PORT_W-1:0]    i_ingress_port,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [MASK_W-1:0]    o_egress_mask,
    output logic [KIND_W-1:0]    o_forward_kind,
    output logic                 o_source_learned,
    output logic                 o_table_full,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_cfg               r_cfg;
    t_mem_req           mem;
    logic [ENTRY_W-1:0] rd_data;
    logic               res_valid;
    logic               res_ready;
    t_result            res;
    logic               r_out_vld;
    t_result            r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bcast_addr   <= BCAST_RESET;
            r_cfg.active_ports <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BCAST_ADDR:   r_cfg.bcast_addr   <= i_cfg_data;
                CFG_ACTIVE_PORTS: r_cfg.active_ports <= i_cfg_data[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    lbf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rd_data)
    );

    lbf_ctrl u_ctrl (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_ingress_port        (i_ingress_port),
        .i_cfg                 (r_cfg),
        .o_mem                 (mem),
        .i_rd_data             (rd_data),
        .o_res_valid           (res_valid),
        .i_res_ready           (res_ready),
        .o_res                 (res)
    );

    assign res_ready = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_egress_mask    = r_out.egress_mask;
    assign o_forward_kind   = r_out.kind;
    assign o_source_learned = r_out.learned;
    assign o_table_full     = r_out.full;

endmodule
